// ----- hw/rtl/hsc_pkg.sv -----
package hsc_pkg;

  // How the second stage finishes a decoded word.
  typedef enum logic [1:0] {
    KIND_DONE,   // result and flags already final
    KIND_WSUB,   // half subnormal widened to single, needs normalizing shift
    KIND_SUB,    // single narrowed into the half subnormal range
    KIND_NORM    // single narrowed into the half normal range
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        sgn;
    logic [31:0] res;
    logic [23:0] sig;
    logic [4:0]  hexp;
    logic [3:0]  shamt;
    logic        sticky;
    logic        ovf;
    logic        unf;
  } dec_t;

  localparam logic [7:0]  F_EXP_SPECIAL  = 8'd255;
  localparam logic [7:0]  F_EXP_OVF      = 8'd143;
  localparam logic [7:0]  F_EXP_SUB_MAX  = 8'd112;
  localparam logic [7:0]  F_EXP_ZERO_MAX = 8'd102;
  localparam logic [7:0]  SUB_BASE       = 8'd113;
  localparam logic [7:0]  WIDEN_BIAS     = 8'd112;
  localparam logic [7:0]  WIDEN_SUB_BIAS = 8'd103;
  localparam logic [4:0]  H_EXP_SPECIAL  = 5'h1f;
  localparam logic [14:0] HALF_INF       = 15'h7c00;
  localparam logic [14:0] HALF_QNAN      = 15'h7c01;
  localparam logic [13:0] TIE_PAT        = 14'h1000;
  localparam logic [23:0] ROUND_HALF     = 24'h001000;
  localparam logic [15:0] HALF_INF_WORD  = 16'h7c00;

  // Position of the highest set bit of a nonzero half significand.
  function automatic logic [3:0] lead_pos(input logic [9:0] s);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (s[i]) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

endpackage

// ----- hw/rtl/hsc_decode.sv -----
module hsc_decode
  import hsc_pkg::*;
(
  input  logic        op,
  input  logic [31:0] value,
  output dec_t        dec
);

  logic        hs;
  logic [4:0]  hex;
  logic [9:0]  hm;
  logic [3:0]  p;
  logic        fs;
  logic [7:0]  fe;
  logic [22:0] fm;
  logic [7:0]  sub_sh;
  logic [23:0] sub_sig;
  logic [31:0] unf_mask;
  logic [31:0] stk_mask;
  logic [7:0]  nexp;

  assign hs       = value[15];
  assign hex      = value[14:10];
  assign hm       = value[9:0];
  assign p        = lead_pos(hm);
  assign fs       = value[31];
  assign fe       = value[30:23];
  assign fm       = value[22:0];
  assign sub_sh   = SUB_BASE - fe;
  assign sub_sig  = {1'b1, fm};
  assign unf_mask = (32'd1 << (5'd13 + {1'b0, sub_sh[3:0]})) - 32'd1;
  assign stk_mask = (32'd1 << sub_sh[3:0]) - 32'd1;
  assign nexp     = fe - F_EXP_SUB_MAX;

  always_comb begin
    dec      = '0;
    dec.kind = KIND_DONE;
    if (op) begin
      dec.sgn = hs;
      if (hex == 5'd0) begin
        if (hm == 10'd0) begin
          dec.res = {hs, 31'd0};
        end else begin
          // Subnormal half: exponent from the leading one, shift in stage two.
          dec.kind  = KIND_WSUB;
          dec.res   = {hs, WIDEN_SUB_BIAS + {4'd0, p}, 23'd0};
          dec.sig   = {14'd0, hm};
          dec.shamt = 4'd10 - p;
        end
      end else if (hex == H_EXP_SPECIAL) begin
        dec.res = {hs, F_EXP_SPECIAL, hm, 13'd0};
      end else begin
        dec.res = {hs, {3'd0, hex} + WIDEN_BIAS, hm, 13'd0};
      end
    end else begin
      dec.sgn = fs;
      if (fe >= F_EXP_OVF) begin
        if (fe == F_EXP_SPECIAL) begin
          if (fm == 23'd0) begin
            dec.res = {16'd0, fs, HALF_INF};
          end else if (fm[22:13] == 10'd0) begin
            // NaN whose payload sits only in dropped bits stays a NaN.
            dec.res = {16'd0, fs, HALF_QNAN};
          end else begin
            dec.res = {16'd0, fs, H_EXP_SPECIAL, fm[22:13]};
          end
        end else begin
          dec.ovf = 1'b1;
          dec.res = {16'd0, fs, HALF_INF};
        end
      end else if (fe <= F_EXP_SUB_MAX) begin
        if (fe < F_EXP_ZERO_MAX) begin
          dec.res = {16'd0, fs, 15'd0};
          dec.unf = |value[30:0];
        end else begin
          dec.kind   = KIND_SUB;
          dec.sig    = sub_sig;
          dec.shamt  = sub_sh[3:0];
          dec.unf    = |({8'd0, sub_sig} & unf_mask);
          dec.sticky = |({8'd0, sub_sig} & stk_mask);
        end
      end else begin
        dec.kind = KIND_NORM;
        dec.hexp = nexp[4:0];
        dec.sig  = {1'b0, fm};
      end
    end
  end

endmodule

// ----- hw/rtl/hsc_round.sv -----
module hsc_round
  import hsc_pkg::*;
(
  input  dec_t        dec,
  input  logic        rte,
  output logic [31:0] result,
  output logic        ovf,
  output logic        unf
);

  logic [9:0]  norm;
  logic [23:0] shifted;
  logic [23:0] rsrc;
  logic        tie;
  logic [23:0] rsum;
  logic [15:0] hsum;

  assign norm    = 10'(dec.sig[9:0] << dec.shamt);
  assign shifted = dec.sig >> dec.shamt;
  assign rsrc    = (dec.kind == KIND_SUB) ? shifted : dec.sig;
  // In the subnormal range a tie only counts when the shift lost nothing.
  assign tie     = rte && (rsrc[13:0] == TIE_PAT) &&
                   !((dec.kind == KIND_SUB) && dec.sticky);
  assign rsum    = rsrc + (tie ? 24'd0 : ROUND_HALF);
  assign hsum    = {1'b0, dec.hexp, 10'd0} + {5'd0, rsum[23:13]};

  always_comb begin
    result = dec.res;
    ovf    = dec.ovf;
    unf    = dec.unf;
    case (dec.kind)
      KIND_DONE: begin
        result = dec.res;
      end
      KIND_WSUB: begin
        result = dec.res | {9'd0, norm, 13'd0};
      end
      KIND_SUB: begin
        result = {16'd0, dec.sgn, 4'd0, rsum[23:13]};
      end
      KIND_NORM: begin
        result = {16'd0, dec.sgn, hsum[14:0]};
        ovf    = (hsum == HALF_INF_WORD);
      end
      default: begin
        result = dec.res;
      end
    endcase
  end

endmodule

// ----- hw/rtl/half_single_float_converter.sv -----
// Half/single float converter, binary16 <-> binary32 bit patterns.
// Input channel: in_valid, in_stall, in_operation (0 single to half,
// 1 half to single) and in_value. Result channel: out_valid, out_stall,
// out_result (a half result in bits 15..0, upper bits zero), out_overflow
// and out_underflow. A word moves when valid is high and stall is low.
// Configuration: cfg_valid/cfg_ready write cfg_round_ties_even; 1 rounds
// ties to even, 0 rounds half up. cfg_ready is always high; write only
// while no word is in flight.
// There are three register stages: an input register, a decode stage
// (classify, shift amount, leading-zero count) and a round stage (variable
// shift and round add) feeding the output register. out_valid rises once a
// word has passed the input and decode registers into the output register.
// Throughput is one word per cycle while out_stall is low. When out_stall
// is high the output word holds; empty stages still fill, so in_stall rises
// only once all three stages hold words. Reset empties the pipeline and sets
// ties-to-even.
module half_single_float_converter
  import hsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result,
  output logic        out_overflow,
  output logic        out_underflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_round_ties_even
);

  logic        rte_r;
  logic        v1_r, v2_r, v3_r;
  logic        op1_r;
  logic [31:0] val1_r;
  dec_t        dec2_r;
  logic [31:0] res3_r;
  logic        ovf3_r, unf3_r;
  logic        load1, load2, load3;
  dec_t        dec_nxt;
  logic [31:0] res_nxt;
  logic        ovf_nxt, unf_nxt;

  assign load3 = !v3_r || !out_stall;
  assign load2 = !v2_r || load3;
  assign load1 = !v1_r || load2;

  assign in_stall      = !load1;
  assign cfg_ready     = 1'b1;
  assign out_valid     = v3_r;
  assign out_result    = res3_r;
  assign out_overflow  = ovf3_r;
  assign out_underflow = unf3_r;

  hsc_decode u_decode (
    .op    (op1_r),
    .value (val1_r),
    .dec   (dec_nxt)
  );

  hsc_round u_round (
    .dec    (dec2_r),
    .rte    (rte_r),
    .result (res_nxt),
    .ovf    (ovf_nxt),
    .unf    (unf_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rte_r <= 1'b1;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rte_r <= cfg_round_ties_even;
      end
      if (load1) begin
        v1_r <= in_valid;
      end
      if (load2) begin
        v2_r <= v1_r;
      end
      if (load3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && in_valid) begin
      op1_r  <= in_operation;
      val1_r <= in_value;
    end
    if (load2 && v1_r) begin
      dec2_r <= dec_nxt;
    end
    if (load3 && v2_r) begin
      res3_r <= res_nxt;
      ovf3_r <= ovf_nxt;
      unf3_r <= unf_nxt;
    end
  end

endmodule

// ----- hw/rtl/hsc_checker.sv -----
module hsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_result,
  input logic        out_overflow,
  input logic        out_underflow
);

  // A stalled output word must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result) &&
    $stable(out_overflow) && $stable(out_underflow))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // An overflowing word is always a half infinity and never underflows.
  a_ovf_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_underflow &&
    out_result[31:16] == 16'd0 && out_result[14:0] == 15'h7c00)
    else $error("overflow flag without half infinity");

  // An underflowing word is zero, a half subnormal or a normal with exponent field one.
  a_unf_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_underflow |-> out_result[31:16] == 16'd0 &&
    out_result[14:11] == 4'd0)
    else $error("underflow flag on a large half result");

endmodule

bind half_single_float_converter hsc_checker u_hsc_checker (.*);
